[src/pra_pkg.sv]
// package for the priority resource allocator: request/response, entry and state types and codes
`default_nettype none

package pra_pkg;

  localparam int NumSlotsDflt = 8;
  localparam int NumTasksDflt = 16;

  localparam int PrioW  = 8;
  localparam int TaskW  = 4;
  localparam int SlotW  = 3;

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_ACQUIRE = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_NO_SLOT  = 2'd2,
    ST_NONE     = 2'd3
  } pra_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } pra_state_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [PrioW-1:0] resource_priority;
    logic [TaskW-1:0] task_id;
    logic [PrioW-1:0] running_priority;
    logic [PrioW-1:0] requester_priority;
  } pra_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [SlotW-1:0] slot_index;
    logic             terminate_task;
  } pra_rsp_t;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [TaskW-1:0] owner;
  } pra_entry_t;

endpackage

`default_nettype wire

[src/priority_resource_allocator.sv]
// top level of the priority resource allocator: slot table memory and scan sequencer
//
//   channel | direction | handshake                 | payload
//   request | in        | req_valid_i / req_ready_o | req_i (pra_req_t)
//   result  | out       | rsp_valid_o / rsp_ready_i | rsp_o (pra_rsp_t)
//
// a scanning request is accepted, then scans the slot table through the
// single read port of the slot memory (stopping at the first hit), and then loads
// the result register; conflict and ignored requests skip the scan.
// free flags are set and written flags are cleared by reset, so no clearing pass runs.
// the result register holds a result until taken; the next request is accepted meanwhile.
`default_nettype none

module priority_resource_allocator
  import pra_pkg::*;
#(
  parameter int NUM_SLOTS = NumSlotsDflt,
  parameter int NUM_TASKS = NumTasksDflt
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  output logic          req_ready_o,
  input  wire pra_req_t req_i,
  output logic          rsp_valid_o,
  input  wire logic     rsp_ready_i,
  output pra_rsp_t      rsp_o
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [CW-1:0] NumSlotsC = CW'(NUM_SLOTS);
  localparam logic [IW-1:0] LastIdx   = IW'(NUM_SLOTS - 1);

  pra_state_e state_q, state_d;
  pra_req_t   req_q, req_d;
  logic [CW-1:0] issue_q, issue_d;
  logic          chk_vld_q, chk_vld_d;
  logic [IW-1:0] chk_idx_q, chk_idx_d;
  logic          best_vld_q, best_vld_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [PrioW-1:0] best_prio_q, best_prio_d;
  logic [NUM_SLOTS-1:0] free_q, free_d;
  logic [NUM_SLOTS-1:0] wr_q, wr_d;
  pra_rsp_t   res_q, res_d;
  pra_rsp_t   rsp_q, rsp_d;
  logic       rsp_valid_q, rsp_valid_d;

  // slot table memory
  pra_entry_t mem [NUM_SLOTS];
  pra_entry_t rdata_q;
  logic       mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_raddr;
  pra_entry_t mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // entry under check
  logic [PrioW-1:0] prio_eff;
  logic             is_last;
  logic             cand;
  logic             nb_vld;
  logic [IW-1:0]    nb_idx;
  logic [PrioW-1:0] nb_prio;

  // never-written entries read as unassigned
  assign prio_eff = wr_q[chk_idx_q] ? rdata_q.prio : '0;
  assign is_last  = (chk_idx_q == LastIdx);
  assign cand     = free_q[chk_idx_q] && (prio_eff >= req_q.resource_priority);

  always_comb begin
    if (cand && (!best_vld_q || (best_prio_q > prio_eff))) begin
      nb_vld  = 1'b1;
      nb_idx  = chk_idx_q;
      nb_prio = prio_eff;
    end else begin
      nb_vld  = best_vld_q;
      nb_idx  = best_idx_q;
      nb_prio = best_prio_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    issue_d     = issue_q;
    chk_vld_d   = chk_vld_q;
    chk_idx_d   = chk_idx_q;
    best_vld_d  = best_vld_q;
    best_idx_d  = best_idx_q;
    best_prio_d = best_prio_q;
    free_d      = free_q;
    wr_d        = wr_q;
    res_d       = res_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q;
    req_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = chk_idx_q;
    mem_raddr   = issue_q[IW-1:0];
    mem_wdata   = '{prio: prio_eff, owner: rdata_q.owner};

    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d      = req_i;
          issue_d    = '0;
          chk_vld_d  = 1'b0;
          best_vld_d = 1'b0;
          state_d    = S_SCAN;
          if ((req_i.operation == OP_ACQUIRE) &&
              (req_i.running_priority > req_i.requester_priority)) begin
            free_d  = '1;
            res_d   = '{status: ST_CONFLICT, slot_index: '0, terminate_task: 1'b1};
            state_d = S_DONE;
          end else if (((req_i.operation != OP_CREATE) &&
                        (req_i.operation != OP_ACQUIRE) &&
                        (req_i.operation != OP_RELEASE)) ||
                       ((req_i.operation == OP_RELEASE) &&
                        (int'(req_i.task_id) >= NUM_TASKS))) begin
            res_d   = '{status: ST_NONE, slot_index: '0, terminate_task: 1'b0};
            state_d = S_DONE;
          end
        end
      end

      S_SCAN: begin
        // read issue runs one entry ahead of the check
        chk_vld_d = (issue_q != NumSlotsC);
        chk_idx_d = issue_q[IW-1:0];
        if (issue_q != NumSlotsC) begin
          issue_d = issue_q + 1'b1;
        end
        if (chk_vld_q) begin
          unique case (req_q.operation)
            OP_CREATE: begin
              if (prio_eff == '0) begin
                mem_we          = 1'b1;
                mem_wdata.prio  = req_q.resource_priority;
                wr_d[chk_idx_q] = 1'b1;
                res_d   = '{status: ST_OK, slot_index: SlotW'(chk_idx_q),
                            terminate_task: 1'b0};
                state_d = S_DONE;
              end else if (is_last) begin
                res_d   = '{status: ST_NONE, slot_index: '0, terminate_task: 1'b0};
                state_d = S_DONE;
              end
            end
            OP_ACQUIRE: begin
              best_vld_d  = nb_vld;
              best_idx_d  = nb_idx;
              best_prio_d = nb_prio;
              if (cand && (prio_eff == req_q.resource_priority)) begin
                mem_we            = 1'b1;
                mem_wdata.owner   = req_q.task_id;
                free_d[chk_idx_q] = 1'b0;
                wr_d[chk_idx_q]   = 1'b1;
                res_d   = '{status: ST_OK, slot_index: SlotW'(chk_idx_q),
                            terminate_task: 1'b0};
                state_d = S_DONE;
              end else if (is_last) begin
                if (nb_vld) begin
                  mem_we         = 1'b1;
                  mem_waddr      = nb_idx;
                  mem_wdata      = '{prio: nb_prio, owner: req_q.task_id};
                  free_d[nb_idx] = 1'b0;
                  wr_d[nb_idx]   = 1'b1;
                  res_d   = '{status: ST_OK, slot_index: SlotW'(nb_idx),
                              terminate_task: 1'b0};
                end else begin
                  free_d = '1;
                  res_d  = '{status: ST_NO_SLOT, slot_index: '0, terminate_task: 1'b1};
                end
                state_d = S_DONE;
              end
            end
            OP_RELEASE: begin
              if (!free_q[chk_idx_q] && (rdata_q.owner == req_q.task_id)) begin
                free_d[chk_idx_q] = 1'b1;
                res_d   = '{status: ST_OK, slot_index: SlotW'(chk_idx_q),
                            terminate_task: 1'b0};
                state_d = S_DONE;
              end else if (is_last) begin
                res_d   = '{status: ST_NONE, slot_index: '0, terminate_task: 1'b0};
                state_d = S_DONE;
              end
            end
            default: begin
              res_d   = '{status: ST_NONE, slot_index: '0, terminate_task: 1'b0};
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_d       = res_q;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_q     <= '0;
      chk_vld_q   <= 1'b0;
      best_vld_q  <= 1'b0;
      free_q      <= '1;
      wr_q        <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      chk_vld_q   <= chk_vld_d;
      best_vld_q  <= best_vld_d;
      free_q      <= free_d;
      wr_q        <= wr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    chk_idx_q   <= chk_idx_d;
    best_idx_q  <= best_idx_d;
    best_prio_q <= best_prio_d;
    res_q       <= res_d;
    rsp_q       <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

[src/pra_checker.sv]
// port-level checker for the priority resource allocator and its bind
`default_nettype none

module pra_checker
  import pra_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     req_valid_i,
  input wire logic     req_ready_o,
  input wire pra_req_t req_i,
  input wire logic     rsp_valid_o,
  input wire logic     rsp_ready_i,
  input wire pra_rsp_t rsp_o
);

  // a waiting request holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_ready_o |=> req_valid_i && $stable(req_i))
    else $error("request changed or dropped while waiting");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result changed or dropped while stalled");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("request accepted while another is in flight");

  // termination goes with exactly the failing acquire codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.terminate_task ==
                     ((rsp_o.status == ST_CONFLICT) || (rsp_o.status == ST_NO_SLOT))))
    else $error("terminate flag disagrees with status");

  // slot index is zero unless ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.status != ST_OK) |-> (rsp_o.slot_index == '0))
    else $error("nonzero slot index on failed request");

endmodule

bind priority_resource_allocator pra_checker u_pra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_ready_o (req_ready_o),
  .req_i       (req_i),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);

`default_nettype wire
